FILE: hdl/pfl_pkg.sv
// ----------------------------------------------------------------------------
// pfl_pkg - page free-list allocator shared definitions
// Widths, codes, controller states and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfl_pkg;

  // page space
  localparam int MAX_PAGES = 1024;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = PAGE_W + 1;

  // extend threshold register
  localparam int PCT_W     = 7;
  localparam int PCT_RESET = 10;
  localparam int PCT_SCALE = 100;
  localparam int PROD_W    = CNT_W + PCT_W;

  // request opcode
  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // response status
  localparam int STAT_W = 2;
  typedef enum logic [STAT_W-1:0] {
    ST_OK  = 2'd0,
    ST_OOS = 2'd1,
    ST_INV = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_POPW,
    S_CHECK,
    S_GROW_A,
    S_GROW_B,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // request taken, reset the result
    logic free_push;  // push the requested page onto the list
    logic set_inv;    // result: invalid free
    logic set_oos;    // result: out of space
    logic grow_init;  // arm the extension walk
    logic grow_step;  // write one new link
    logic mem_read;   // read link of the head
    logic pop;        // take the head, follow its link
    logic load_out;   // move the result to the response register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_free;   // request is a free
    logic free_ok;    // requested free is legal
    logic empty;      // free count is zero
    logic full;       // page space at capacity
    logic ratio_hit;  // free ratio at or below threshold
    logic grow_end;   // walk is at its last page
    logic out_free;   // response register can take a result
  } sts_t;

endpackage

FILE: hdl/pfl_req_if.sv
// ----------------------------------------------------------------------------
// pfl_req_if - allocator request channel
// valid/ready handshake carrying an opcode and a page index.
// ----------------------------------------------------------------------------
interface pfl_req_if;
  import pfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [0:0]        opcode;
  logic [PAGE_W-1:0] page_index;

  modport source (output valid, output opcode, output page_index, input ready);
  modport sink   (input valid, input opcode, input page_index, output ready);
endinterface

FILE: hdl/pfl_rsp_if.sv
// ----------------------------------------------------------------------------
// pfl_rsp_if - allocator response channel
// valid/ready handshake carrying page, status and the extension flag.
// ----------------------------------------------------------------------------
interface pfl_rsp_if;
  import pfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;
  logic [STAT_W-1:0] status;
  logic              extended;

  modport source (output valid, output page, output status, output extended, input ready);
  modport sink   (input valid, input page, input status, input extended, output ready);
endinterface

FILE: hdl/page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator - linked free-list page allocator
// LIFO free list of page indices with on-demand doubling of the page space.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   opcode, page_index
//   rsp      out  valid/ready   page, status, extended
//   cfg      in   cfg_we        cfg_wdata (extend_percent)
//
// A free goes from idle straight to response; an allocate steps through pop,
// pop-wait and check, bound by the link memory's registered read. An extension
// writes one new link per cycle. One request is in flight at a time; the
// response register lets the next request enter while a result waits.
// Synchronous active-high reset; the link memory itself is not cleared.
// ----------------------------------------------------------------------------
module page_free_list_allocator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pfl_pkg::PCT_W-1:0] cfg_wdata,
  pfl_req_if.sink                   req,
  pfl_rsp_if.source                 rsp
);
  import pfl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  pfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  pfl_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .req_opcode     (req.opcode),
    .req_page_index (req.page_index),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_page       (rsp.page),
    .rsp_status     (rsp.status),
    .rsp_extended   (rsp.extended),
    .cmd            (cmd),
    .sts            (sts)
  );

`ifndef SYNTHESIS
  // out of space gives page 0 and no extension
  a_oos_result: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_OOS) |-> (rsp.page == '0 && !rsp.extended))
    else $error("out-of-space response with page or extension set");

  // a rejected free never grows the space
  a_inv_no_ext: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_INV) |-> !rsp.extended)
    else $error("invalid free reported an extension");

  // one request at a time: a taken request closes the input
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in flight");

  // the walk never starts at capacity
  a_no_grow_full: assert property (@(posedge clk) disable iff (rst)
    cmd.grow_init |-> !sts.full)
    else $error("extension started with no room left");
`endif

endmodule

FILE: hdl/pfl_ctrl.sv
// ----------------------------------------------------------------------------
// pfl_ctrl - allocator controller
// Sequences one request at a time: pop, push, extension walk and response.
// ----------------------------------------------------------------------------
module pfl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pfl_pkg::sts_t  sts,
  output pfl_pkg::cmd_t  cmd
);
  import pfl_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (sts.req_free) begin
            state_next = S_RESP;
          end else if (sts.empty) begin
            state_next = sts.full ? S_RESP : S_GROW_A;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_GROW_A: if (sts.grow_end) state_next = S_POP;
      S_POP:    state_next = S_POPW;
      S_POPW:   state_next = S_CHECK;
      S_CHECK: begin
        state_next = (sts.ratio_hit && !sts.full) ? S_GROW_B : S_RESP;
      end
      S_GROW_B: if (sts.grow_end) state_next = S_RESP;
      S_RESP:   if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch = 1'b1;
          if (sts.req_free) begin
            cmd.free_push = sts.free_ok;
            cmd.set_inv   = !sts.free_ok;
          end else if (sts.empty) begin
            cmd.set_oos   = sts.full;
            cmd.grow_init = !sts.full;
          end
        end
      end
      S_GROW_A: cmd.grow_step = 1'b1;
      S_POP:    cmd.mem_read  = 1'b1;
      S_POPW:   cmd.pop       = 1'b1;
      S_CHECK:  cmd.grow_init = sts.ratio_hit && !sts.full;
      S_GROW_B: cmd.grow_step = 1'b1;
      S_RESP:   cmd.load_out  = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

FILE: hdl/pfl_dp.sv
// ----------------------------------------------------------------------------
// pfl_dp - allocator datapath
// Link memory, list head and counters, threshold register, result and
// response registers.
// ----------------------------------------------------------------------------
module pfl_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [pfl_pkg::PCT_W-1:0]  cfg_wdata,
  input  logic [0:0]                 req_opcode,
  input  logic [pfl_pkg::PAGE_W-1:0] req_page_index,
  input  logic                       rsp_ready,
  output logic                       rsp_valid,
  output logic [pfl_pkg::PAGE_W-1:0] rsp_page,
  output logic [pfl_pkg::STAT_W-1:0] rsp_status,
  output logic                       rsp_extended,
  input  pfl_pkg::cmd_t              cmd,
  output pfl_pkg::sts_t              sts
);
  import pfl_pkg::*;

  logic [PAGE_W-1:0] link_mem [MAX_PAGES];
  logic [PAGE_W-1:0] link_rd;

  logic [PAGE_W-1:0] head;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  page_count;
  logic [PCT_W-1:0]  extend_percent;

  logic [PAGE_W-1:0] grow_ptr;
  logic [PAGE_W-1:0] grow_last;

  logic [PAGE_W-1:0] res_page;
  status_t           res_status;
  logic              res_ext;

  logic              mem_we;
  logic [PAGE_W-1:0] mem_wa;
  logic [PAGE_W-1:0] mem_wd;
  logic [PAGE_W-1:0] grow_wd;
  logic [CNT_W:0]    pc_double;
  logic [PAGE_W-1:0] last_calc;
  logic [PROD_W-1:0] free_scaled;
  logic [PROD_W-1:0] total_scaled;
  logic [CNT_W:0]    fc_plus1;

  // link written during the walk: base page takes the old head
  assign grow_wd = (grow_ptr == page_count[PAGE_W-1:0]) ? head : grow_ptr - 1'b1;

  // memory write port select
  assign mem_we = cmd.free_push | cmd.grow_step;
  assign mem_wa = cmd.grow_step ? grow_ptr : req_page_index;
  assign mem_wd = cmd.grow_step ? grow_wd : head;

  // link memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (cmd.mem_read) begin
      link_rd <= link_mem[head];
    end
  end

  // last page of the walk: doubled space, capped at capacity
  assign pc_double = {page_count, 1'b0} - 1'b1;
  assign last_calc = (page_count <= CNT_W'(MAX_PAGES / 2)) ? pc_double[PAGE_W-1:0]
                                                           : PAGE_W'(MAX_PAGES - 1);

  // ratio check and free legality
  assign free_scaled  = PROD_W'(free_count) * PROD_W'(PCT_SCALE);
  assign total_scaled = PROD_W'(extend_percent) * PROD_W'(page_count);
  assign fc_plus1     = {1'b0, free_count} + 1'b1;

  always_comb begin
    sts.req_free  = (req_opcode == OP_FREE);
    sts.free_ok   = (req_page_index != '0) &&
                    ({1'b0, req_page_index} < page_count) &&
                    (fc_plus1 < {1'b0, page_count});
    sts.empty     = (free_count == '0);
    sts.full      = (page_count == CNT_W'(MAX_PAGES));
    sts.ratio_hit = (free_scaled <= total_scaled);
    sts.grow_end  = (grow_ptr == grow_last);
    sts.out_free  = !rsp_valid || rsp_ready;
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      extend_percent <= PCT_W'(PCT_RESET);
    end else if (cfg_we) begin
      extend_percent <= cfg_wdata;
    end
  end

  // list head and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      free_count <= '0;
      page_count <= CNT_W'(1);
    end else begin
      if (cmd.free_push) begin
        head       <= req_page_index;
        free_count <= free_count + 1'b1;
      end
      if (cmd.pop) begin
        head       <= link_rd;
        free_count <= free_count - 1'b1;
      end
      if (cmd.grow_step && sts.grow_end) begin
        head       <= grow_ptr;
        page_count <= {1'b0, grow_ptr} + 1'b1;
        free_count <= free_count + ({1'b0, grow_ptr} + 1'b1 - page_count);
      end
    end
  end

  // extension walk pointer
  always_ff @(posedge clk) begin
    if (cmd.grow_init) begin
      grow_ptr  <= page_count[PAGE_W-1:0];
      grow_last <= last_calc;
    end else if (cmd.grow_step && !sts.grow_end) begin
      grow_ptr <= grow_ptr + 1'b1;
    end
  end

  // result being built
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_page   <= cmd.set_oos ? '0 : req_page_index;
      res_status <= cmd.set_oos ? ST_OOS : (cmd.set_inv ? ST_INV : ST_OK);
      res_ext    <= 1'b0;
    end else begin
      if (cmd.pop) begin
        res_page <= head;
      end
      if (cmd.grow_step && sts.grow_end) begin
        res_ext <= 1'b1;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_page     <= res_page;
      rsp_status   <= res_status;
      rsp_extended <= res_ext;
    end
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - page_free_list_allocator regression bench
// Drives allocate and free requests with random stalls on both channels,
// predicts every response with a cycle-free model of the free list and the
// doubling rule, and compares each response field by field in order.
// The run walks the extend threshold through zero, 127, a mid value, 100 and a
// random value, fills the page space to capacity and drains the list dry.
// ----------------------------------------------------------------------------
module tb;
  import pfl_pkg::*;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    status_t           status;
    logic              ext;
  } alloc_rsp_t;

  // Predictor of the allocator plus the queue of responses still owed
  class alloc_scoreboard;
    logic [PAGE_W-1:0] link_mem [MAX_PAGES];
    logic [PAGE_W-1:0] head;
    int unsigned       free_cnt;
    int unsigned       page_cnt;
    int unsigned       pct;
    alloc_rsp_t        pending [$];
    int                errors;

    function new();
      foreach (link_mem[i]) link_mem[i] = '0;
      head     = '0;
      free_cnt = 0;
      page_cnt = 1;
      pct      = PCT_RESET;
      errors   = 0;
    endfunction

    // double the page space, capped; new pages chain down onto the old head
    function bit grow_space();
      int unsigned base;
      int unsigned size;
      base = page_cnt;
      size = (MAX_PAGES - base < base) ? MAX_PAGES - base : base;
      if (size == 0) return 1'b0;
      link_mem[base] = head;
      for (int unsigned p = base + 1; p < base + size; p++) link_mem[p] = PAGE_W'(p - 1);
      head     = PAGE_W'(base + size - 1);
      page_cnt = base + size;
      free_cnt = free_cnt + size;
      return 1'b1;
    endfunction

    // accepted request: update state and queue the response it owes
    function alloc_rsp_t note_request(op_t op, logic [PAGE_W-1:0] idx);
      alloc_rsp_t r;
      r.page   = '0;
      r.status = ST_OK;
      r.ext    = 1'b0;
      if (op == OP_ALLOC) begin
        if (free_cnt == 0 && grow_space()) r.ext = 1'b1;
        if (free_cnt == 0) begin
          r.status = ST_OOS;
          r.ext    = 1'b0;
        end else begin
          r.page   = head;
          head     = link_mem[head];
          free_cnt = free_cnt - 1;
          if (free_cnt * PCT_SCALE <= pct * page_cnt && grow_space()) r.ext = 1'b1;
        end
      end else begin
        r.page = idx;
        if (idx == 0 || idx >= page_cnt || free_cnt + 1 >= page_cnt) begin
          r.status = ST_INV;
        end else begin
          link_mem[idx] = head;
          head          = idx;
          free_cnt      = free_cnt + 1;
        end
      end
      pending.push_back(r);
      return r;
    endfunction

    task report(string what);
      errors++;
      $display("%0t  mismatch: %s", $time, what);
    endtask

    // accepted response: compare with the oldest owed one
    task check_response(logic [PAGE_W-1:0] page, logic [STAT_W-1:0] status, logic ext);
      alloc_rsp_t want;
      if (pending.size() == 0) begin
        report($sformatf("response page=%0d status=%0d with no request open", page, status));
      end else begin
        want = pending.pop_front();
        if (page !== want.page)
          report($sformatf("page %0d, predicted %0d", page, want.page));
        if (status !== want.status)
          report($sformatf("status %0d, predicted %0d (page %0d)", status, want.status,
                           want.page));
        if (ext !== want.ext)
          report($sformatf("extended %0b, predicted %0b (page %0d)", ext, want.ext,
                           want.page));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [PCT_W-1:0] cfg_wdata;

  pfl_req_if req_bus ();
  pfl_rsp_if rsp_bus ();

  page_free_list_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_bus.sink),
    .rsp       (rsp_bus.source)
  );

  alloc_scoreboard sb = new();
  int              held_pages [$];  // pages handed out and not yet returned
  int              oos_seen = 0;
  bit              steady = 1'b0;   // no stalls on either side

  always #10 clk = ~clk;

  // Response side: random stall bursts, with calm stretches between
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_bus.valid && rsp_bus.ready)
        sb.check_response(rsp_bus.page, rsp_bus.status, rsp_bus.extended);
      if (stall_left != 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        rsp_bus.ready <= 1'b1;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 120);
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // One request, with an occasional idle burst ahead of it
  task automatic send_req(op_t op, logic [PAGE_W-1:0] idx);
    alloc_rsp_t r;
    int         k;
    if (!steady && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.opcode     <= op;
    req_bus.page_index <= idx;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    r = sb.note_request(op, idx);
    if (op == OP_ALLOC && r.status == ST_OK) held_pages.push_back(r.page);
    if (op == OP_ALLOC && r.status == ST_OOS) oos_seen++;
    if (op == OP_FREE && r.status == ST_OK) begin
      k = -1;
      foreach (held_pages[i]) if (k < 0 && held_pages[i] == idx) k = i;
      if (k >= 0) held_pages.delete(k);
    end
  endtask

  // Return a page this side holds
  task automatic free_held();
    send_req(OP_FREE, PAGE_W'(held_pages[$urandom_range(0, held_pages.size() - 1)]));
  endtask

  // Let every response come back, then write the threshold
  task automatic write_percent(int unsigned value);
    req_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= PCT_W'(value);
    @(posedge clk);
    sb.pct = value;
    cfg_we <= 1'b0;
  endtask

  // Mostly legal traffic, some stray and repeated frees
  task automatic run_mixed(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 45 || (r < 85 && held_pages.size() == 0))
        send_req(OP_ALLOC, PAGE_W'($urandom_range(0, 1023)));
      else if (r < 85)
        free_held();
      else if (r < 91)
        send_req(OP_FREE, PAGE_W'($urandom_range(0, 1023)));
      else if (r < 97)
        send_req(OP_FREE,
                 PAGE_W'($urandom_range(1, sb.page_cnt > 1 ? sb.page_cnt - 1 : 1)));
      else
        send_req(OP_FREE, 0);
    end
  endtask

  // Stimulus
  initial begin
    int pg;
    int guard;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req_bus.valid      = 1'b0;
    req_bus.opcode     = OP_ALLOC;
    req_bus.page_index = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: header page, out-of-range pages, first extension on empty list
    send_req(OP_FREE, 10'd0);
    send_req(OP_FREE, 10'h3FF);
    send_req(OP_FREE, 10'd1);
    send_req(OP_ALLOC, 10'h3FF);
    send_req(OP_ALLOC, 10'h000);
    pg = held_pages[$];
    send_req(OP_FREE, PAGE_W'(pg));
    send_req(OP_FREE, PAGE_W'(pg));      // second free of the same page, not caught
    repeat (6) send_req(OP_ALLOC, PAGE_W'($urandom_range(0, 1023)));
    pg = held_pages[0];
    send_req(OP_FREE, PAGE_W'(pg));
    send_req(OP_FREE, PAGE_W'(pg));      // double free, not caught
    send_req(OP_ALLOC, 10'h155);
    send_req(OP_ALLOC, 10'h2AA);
    send_req(OP_FREE, 10'h155);
    send_req(OP_FREE, 10'h2AA);
    send_req(OP_FREE, 10'h3FF);
    free_held();

    // threshold sweep
    write_percent(0);
    run_mixed(250);
    write_percent(127);
    run_mixed(250);
    write_percent($urandom_range(1, 99));
    run_mixed(250);

    // fill to capacity and drain the list until allocations fail
    write_percent(100);
    guard = 0;
    while (oos_seen < 6 && guard < 1600) begin
      if ($urandom_range(0, 99) < 92 || held_pages.size() == 0)
        send_req(OP_ALLOC, PAGE_W'($urandom_range(0, 1023)));
      else
        free_held();
      guard++;
    end

    // at capacity, no stalls
    write_percent($urandom_range(0, 127));
    steady = 1'b1;
    run_mixed(150);
    req_bus.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("page_free_list_allocator regression: pass");
    end else begin
      $display("page_free_list_allocator regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("page_free_list_allocator regression: fail");
    $finish;
  end

endmodule
